// ----- hw/rtl/arre_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acknowledgement range record encoder package
// Shared constants, command codes and the back end state type.
// ----------------------------------------------------------------------------
package arre_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int SEQ_BITS_DEF    = 24;
	localparam int ID_BITS         = 8;
	localparam int IDX_BITS        = 6;

	typedef enum logic {
		ACT_PUSH  = 1'b0,
		ACT_FLUSH = 1'b1
	} action_t;

	localparam logic SINGLE_CODE = 1'b1;
	localparam logic RANGE_CODE  = 1'b0;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_WAIT,
		BK_READ,
		BK_WALK,
		BK_EMIT
	} back_state_t;

endpackage

// ----- hw/rtl/arre_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload of parameter width with a source and a sink side.
// ----------------------------------------------------------------------------
interface arre_if #(
	parameter int W = 1
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/arre_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module arre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/arre_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end: sorted store
// Keeps pushed numbers in ascending order in a register shift chain and
// shifts them out, smallest first, into the back end RAM on a flush.
// ----------------------------------------------------------------------------
module arre_front import arre_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int SEQ_BITS    = SEQ_BITS_DEF,
	parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_action,
	input  logic [SEQ_BITS-1:0] in_seq,
	// flush request towards the back end queue
	output logic                fl_valid,
	input  logic                fl_ready,
	output logic [CW-1:0]       fl_count,
	output logic                fl_ovf,
	// write port into the back end RAM copy
	output logic                cp_we,
	output logic [$clog2(MAX_ENTRIES)-1:0] cp_addr,
	output logic [SEQ_BITS-1:0] cp_data,
	input  logic                back_busy
);
	localparam int AW = $clog2(MAX_ENTRIES);

	logic [SEQ_BITS-1:0] store_q [MAX_ENTRIES];
	logic [CW-1:0]       count_q;
	logic                drop_q;
	logic                copying_q;
	logic [CW-1:0]       cp_idx_q;
	logic                push;
	logic                flush_go;

	// Ready only while not copying and, for a flush, the back end is free.
	assign in_ready = !copying_q && !(in_action == ACT_FLUSH && (back_busy || !fl_ready));
	assign push     = in_valid && in_ready && in_action == ACT_PUSH;
	assign flush_go = in_valid && in_ready && in_action == ACT_FLUSH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			drop_q    <= 1'b0;
			copying_q <= 1'b0;
			cp_idx_q  <= '0;
		end else begin
			if (push) begin
				if (count_q == CW'(MAX_ENTRIES)) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (flush_go) begin
				drop_q   <= 1'b0;
				cp_idx_q <= '0;
				if (count_q != '0) begin
					copying_q <= 1'b1;
				end
			end else if (copying_q) begin
				if (cp_idx_q + 1'b1 == count_q) begin
					copying_q <= 1'b0;
					count_q   <= '0;
				end
				cp_idx_q <= cp_idx_q + 1'b1;
			end
		end
	end

	// Insertion: each cell keeps, takes its left neighbor, or takes the new number.
	// While copying, the chain shifts down so the head cell always holds the
	// next entry to be written into the RAM.
	always_ff @(posedge clk) begin
		if (push && count_q != CW'(MAX_ENTRIES)) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (CW'(i) <= count_q) begin
					if (i == 0) begin
						if (CW'(i) == count_q || store_q[0] > in_seq) begin
							store_q[0] <= in_seq;
						end
					end else if (CW'(i) == count_q || store_q[i] > in_seq) begin
						if (store_q[i-1] > in_seq) begin
							store_q[i] <= store_q[i-1];
						end else begin
							store_q[i] <= in_seq;
						end
					end
				end
			end
		end else if (copying_q) begin
			for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
				store_q[i] <= store_q[i+1];
			end
		end
	end

	assign fl_valid = flush_go;
	assign fl_count = count_q;
	assign fl_ovf   = drop_q;
	assign cp_we    = copying_q;
	assign cp_addr  = cp_idx_q[AW-1:0];
	assign cp_data  = store_q[0];
endmodule

// ----- hw/rtl/arre_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end: record walker
// Walks the sorted copy, a RAM read then a compare per entry, and emits run records.
// ----------------------------------------------------------------------------
module arre_back import arre_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int SEQ_BITS    = SEQ_BITS_DEF,
	parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fl_valid,
	output logic                fl_ready,
	input  logic [CW-1:0]       fl_count,
	input  logic                fl_ovf,
	input  logic                cp_we,
	input  logic [$clog2(MAX_ENTRIES)-1:0] cp_addr,
	input  logic [SEQ_BITS-1:0] cp_data,
	output logic                busy,
	input  logic [ID_BITS-1:0]  packet_id,
	arre_if.source              res
);
	localparam int AW = $clog2(MAX_ENTRIES);

	back_state_t          st_q, st_d;
	logic [CW-1:0]        cnt_q, idx_q;
	logic                 ovf_q;
	logic [SEQ_BITS-1:0]  first_q, prev_q, rdata;
	logic [IDX_BITS-1:0]  rec_q;
	logic                 empty_q, fin_q;
	logic                 ov_q;
	logic [SEQ_BITS-1:0]  diff;
	logic                 is_last;
	logic                 brk;

	// The read address stays on the current entry from READ through EMIT, so
	// rdata holds that entry for as long as the walk is held.
	arre_ram #(.WIDTH(SEQ_BITS), .DEPTH(MAX_ENTRIES)) u_ram (
		.clk(clk), .we(cp_we), .waddr(cp_addr), .wdata(cp_data),
		.raddr(idx_q[AW-1:0]), .rdata(rdata)
	);

	assign fl_ready = st_q == BK_IDLE;
	assign busy     = st_q != BK_IDLE;
	assign diff     = rdata - prev_q;
	assign is_last  = idx_q + 1'b1 == cnt_q;
	assign brk      = (idx_q != '0) && (diff > SEQ_BITS'(1));

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (fl_valid) st_d = (fl_count == '0) ? BK_EMIT : BK_WAIT;
			BK_WAIT: st_d = BK_READ;
			BK_READ: st_d = BK_WALK;
			BK_WALK: st_d = (brk || is_last) ? BK_EMIT : BK_READ;
			BK_EMIT: if (res.ready) begin
				if (fin_q) st_d = BK_IDLE;
				else if (is_last) st_d = BK_EMIT;
				else st_d = BK_READ;
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			idx_q <= '0; cnt_q <= '0; ovf_q <= 1'b0; rec_q <= '0;
			empty_q <= 1'b0; fin_q <= 1'b0; ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				BK_IDLE: if (fl_valid) begin
					cnt_q <= fl_count; ovf_q <= fl_ovf; rec_q <= '0;
					idx_q <= '0; empty_q <= fl_count == '0;
					fin_q <= fl_count == '0; ov_q <= fl_ovf && fl_count == '0;
				end
				BK_WALK: begin
					if (!brk) begin
						if (is_last) begin
							fin_q <= 1'b1; ov_q <= ovf_q;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				BK_EMIT: if (res.ready) begin
					rec_q <= rec_q + 1'b1;
					if (!fin_q) begin
						if (is_last) begin
							fin_q <= 1'b1; ov_q <= ovf_q;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Run tracking: the first entry opens a run, a step of one extends it, a
	// repeat leaves it alone, and the entry after a gap opens the next run
	// once the closed run has been taken.
	always_ff @(posedge clk) begin
		if (st_q == BK_WALK) begin
			if (idx_q == '0) begin
				first_q <= rdata; prev_q <= rdata;
			end else if (diff == SEQ_BITS'(1)) begin
				prev_q <= rdata;
			end
		end
		if (st_q == BK_EMIT && res.ready && !fin_q) begin
			first_q <= rdata; prev_q <= rdata;
		end
	end

	assign res.valid = st_q == BK_EMIT;
	assign res.data  = {!empty_q,
		empty_q ? 1'b0 : ((first_q == prev_q) ? SINGLE_CODE : RANGE_CODE),
		empty_q ? {SEQ_BITS{1'b0}} : first_q,
		empty_q ? {SEQ_BITS{1'b0}} : prev_q,
		rec_q, packet_id, ov_q, fin_q};
endmodule

// ----- hw/rtl/ack_range_record_encoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acknowledgement range record encoder
// Sorts pushed sequence numbers and emits run records on a flush.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries {action, seq_number}. A push request is taken
// while no copy runs and is inserted into a sorted register chain at once;
// pushes beyond capacity are dropped and flagged on the last record of the
// flush. A flush request is taken when the back end is free; the front end
// then shifts its count of entries into the back end RAM, one entry a cycle,
// while it takes no requests, so pushes resume once the copy is done.
// The back end passes a wait state, then for each entry a RAM read state
// and a compare state, and an emit state for each record it presents; a
// stalled receiver simply holds the walk. An empty flush skips the walk and
// gives its one record, marked as not valid and with last set, in the cycle
// after the flush is taken.
// Reset clears the count, the dropped flag and both controllers; the stored
// numbers themselves are not cleared. packet_id is written by cfg_we.
// Result data order: record_valid, is_single, range_start, range_end,
// record_index, header_id, overflow, last (MSB first).
// ----------------------------------------------------------------------------
module ack_range_record_encoder_core import arre_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int SEQ_BITS    = SEQ_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [ID_BITS-1:0] cfg_wdata,
	arre_if.sink               req,
	arre_if.source             res
);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = $clog2(MAX_ENTRIES);

	logic [ID_BITS-1:0]  packet_id_q;
	logic                fl_valid, fl_ready, fl_ovf, cp_we, back_busy;
	logic [CW-1:0]       fl_count;
	logic [AW-1:0]       cp_addr;
	logic [SEQ_BITS-1:0] cp_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_id_q <= '0;
		end else if (cfg_we) begin
			packet_id_q <= cfg_wdata;
		end
	end

	arre_front #(.MAX_ENTRIES(MAX_ENTRIES), .SEQ_BITS(SEQ_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.in_action(req.data[SEQ_BITS]), .in_seq(req.data[SEQ_BITS-1:0]),
		.fl_valid(fl_valid), .fl_ready(fl_ready), .fl_count(fl_count), .fl_ovf(fl_ovf),
		.cp_we(cp_we), .cp_addr(cp_addr), .cp_data(cp_data), .back_busy(back_busy)
	);

	arre_back #(.MAX_ENTRIES(MAX_ENTRIES), .SEQ_BITS(SEQ_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.fl_valid(fl_valid), .fl_ready(fl_ready), .fl_count(fl_count), .fl_ovf(fl_ovf),
		.cp_we(cp_we), .cp_addr(cp_addr), .cp_data(cp_data), .busy(back_busy),
		.packet_id(packet_id_q), .res(res)
	);
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acknowledgement range record encoder testbench
// Drives pushes and flushes with random idling on both channels, rebuilds the
// sorted store in a local model and checks every emitted record in order.
// ----------------------------------------------------------------------------
module tb_top;
	import arre_pkg::*;

	localparam int SEQ_W      = SEQ_BITS_DEF;
	localparam int CAPACITY   = MAX_ENTRIES_DEF;
	localparam int RANDOM_REQ = 200;
	// Quiet time after the last expected record, before the id is written or the run ends.
	localparam int DRAIN_WAIT = 200;
	localparam int STALL_MAX  = 5000;
	localparam int HOLD_LEN   = 400;

	// Record layout, MSB first, as the result channel carries it.
	typedef struct packed {
		logic               rec_valid;
		logic               single;
		logic [SEQ_W-1:0]   first;
		logic [SEQ_W-1:0]   final_num;
		logic [IDX_BITS-1:0] idx;
		logic [ID_BITS-1:0] hdr;
		logic               ovf;
		logic               lst;
	} ack_rec_t;

	// One row of the directed table. When known is set the flush yields the
	// single record typed in the row; otherwise the local model decides.
	typedef struct {
		action_t  act;
		logic [SEQ_W-1:0] num;
		bit       known;
		ack_rec_t rec;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ID_BITS-1:0] cfg_wdata;

	arre_if #(.W(SEQ_W + 1)) req ();
	arre_if #(.W($bits(ack_rec_t))) res ();

	ack_range_record_encoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.res      (res)
	);

	// Local copy of the block's state.
	logic [SEQ_W-1:0]   sorted_nums[$];
	bit                 lost_push;
	logic [ID_BITS-1:0] cur_id;

	// Records still to come, oldest first.
	ack_rec_t pending_recs[$];

	int  errors;
	int  idle_cycles;
	bit  hold_go;
	bit  hold_done;
	int  rdy_gap;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Appends a record at the tail of a record queue.
	function automatic void append_rec(ref ack_rec_t q[$], input ack_rec_t r);
		q.insert(q.size(), r);
	endfunction

	// Appends a row at the tail of the directed table.
	function automatic void append_row(ref dir_row_t q[$], input dir_row_t d);
		q.insert(q.size(), d);
	endfunction

	// Inserts a number behind any equal ones; a full store drops it.
	function automatic void store_number(logic [SEQ_W-1:0] v);
		int pos;
		if (sorted_nums.size() >= CAPACITY) begin
			lost_push = 1'b1;
			return;
		end
		pos = sorted_nums.size();
		while (pos > 0 && sorted_nums[pos-1] > v)
			pos--;
		sorted_nums.insert(pos, v);
	endfunction

	// Walks the store and builds the run records of one flush. Repeated
	// numbers fall into the run they belong to; a gap closes the run.
	function automatic void build_records(ref ack_rec_t recs[$]);
		ack_rec_t r;
		logic [SEQ_W-1:0] run_lo;
		logic [SEQ_W-1:0] run_hi;
		int n;
		n = 0;
		recs = {};
		if (sorted_nums.size() == 0) begin
			r = '0;
			r.hdr = cur_id;
			r.ovf = lost_push;
			r.lst = 1'b1;
			append_rec(recs, r);
		end else begin
			run_lo = sorted_nums[0];
			run_hi = run_lo;
			for (int i = 1; i < sorted_nums.size(); i++) begin
				if (sorted_nums[i] == run_hi + 1) begin
					run_hi = sorted_nums[i];
				end else if (sorted_nums[i] != run_hi) begin
					r = '0;
					r.rec_valid = 1'b1;
					r.single = (run_lo == run_hi) ? SINGLE_CODE : RANGE_CODE;
					r.first = run_lo;
					r.final_num = run_hi;
					r.idx = IDX_BITS'(n);
					r.hdr = cur_id;
					append_rec(recs, r);
					n++;
					run_lo = sorted_nums[i];
					run_hi = run_lo;
				end
			end
			r = '0;
			r.rec_valid = 1'b1;
			r.single = (run_lo == run_hi) ? SINGLE_CODE : RANGE_CODE;
			r.first = run_lo;
			r.final_num = run_hi;
			r.idx = IDX_BITS'(n);
			r.hdr = cur_id;
			r.ovf = lost_push;
			r.lst = 1'b1;
			append_rec(recs, r);
		end
		sorted_nums = {};
		lost_push = 1'b0;
	endfunction

	// Offers one request after a random gap and returns at the falling edge
	// after it was taken. Valid is left high so back-to-back requests never
	// lower and raise it in the same step.
	task automatic send_req(action_t act, logic [SEQ_W-1:0] num, bit known,
	                        ack_rec_t typed);
		int r;
		int gap;
		ack_rec_t recs[$];
		r = $urandom_range(99);
		if (r < 55)
			gap = 0;
		else if (r < 93)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= {act, num};
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		// Taken at this edge: update the local model.
		if (act == ACT_PUSH) begin
			store_number(num);
		end else begin
			build_records(recs);
			if (known)
				append_rec(pending_recs, typed);
			else
				foreach (recs[i])
					append_rec(pending_recs, recs[i]);
		end
		@(negedge clk);
	endtask

	// Waits until every record is in and the back end has surely gone quiet,
	// then writes the packet id.
	task automatic write_id(logic [ID_BITS-1:0] v);
		req.valid <= 1'b0;
		while (pending_recs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_id = v;
	endtask

	// Receiver side: short random stalls, rare long ones, and one long hold
	// on request so the block backs up into its request channel.
	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			rdy_gap <= HOLD_LEN;
			res.ready <= 1'b0;
		end else if (rdy_gap > 0) begin
			rdy_gap <= rdy_gap - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
			case ($urandom_range(99)) inside
				[0:17]:  rdy_gap <= $urandom_range(1, 3);
				[18:20]: rdy_gap <= $urandom_range(10, 40);
				default: rdy_gap <= 0;
			endcase
		end
	end

	// Compares each accepted record with the oldest one expected.
	always @(posedge clk) begin
		ack_rec_t got;
		ack_rec_t want;
		if (arst_n && res.valid && res.ready) begin
			got = res.data;
			if (pending_recs.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected record %p", got);
			end else begin
				want = pending_recs.pop_front();
				if (got.rec_valid !== want.rec_valid || got.single !== want.single ||
				    got.first !== want.first || got.final_num !== want.final_num ||
				    got.idx !== want.idx || got.hdr !== want.hdr ||
				    got.ovf !== want.ovf || got.lst !== want.lst) begin
					errors++;
					if (errors <= 10)
						$display("record mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	// Watchdog: any stretch without a request or a record taken is a hang.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_MAX) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		dir_row_t rows[$];
		dir_row_t row;
		logic [ID_BITS-1:0] ids[4];
		logic [SEQ_W-1:0] base;
		int sent;
		int burst;
		int len;
		int style;
		int r;

		errors = 0;
		idle_cycles = 0;
		hold_go = 1'b0;
		hold_done = 1'b0;
		rdy_gap = 0;
		lost_push = 1'b0;
		cur_id = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.data = '0;
		res.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, run with the packet id still at its reset value.
		// Empty flush right after reset.
		append_row(rows, '{ACT_FLUSH, '0, 1'b1,
		                   '{1'b0, 1'b0, '0, '0, '0, '0, 1'b0, 1'b1}});
		// Largest number alone.
		append_row(rows, '{ACT_PUSH, 24'hFF_FFFF, 1'b0, '0});
		append_row(rows, '{ACT_FLUSH, '0, 1'b1,
		                   '{1'b1, SINGLE_CODE, 24'hFF_FFFF, 24'hFF_FFFF, '0, '0,
		                     1'b0, 1'b1}});
		// Zero alone.
		append_row(rows, '{ACT_PUSH, '0, 1'b0, '0});
		append_row(rows, '{ACT_FLUSH, 24'hAA_AAAA, 1'b1,
		                   '{1'b1, SINGLE_CODE, '0, '0, '0, '0, 1'b0, 1'b1}});
		// A plain two-number run.
		append_row(rows, '{ACT_PUSH, 24'd10, 1'b0, '0});
		append_row(rows, '{ACT_PUSH, 24'd11, 1'b0, '0});
		append_row(rows, '{ACT_FLUSH, 24'h55_5555, 1'b1,
		                   '{1'b1, RANGE_CODE, 24'd10, 24'd11, '0, '0, 1'b0, 1'b1}});
		// Out of order, with a repeated number inside a run and a lone one.
		append_row(rows, '{ACT_PUSH, 24'd5, 1'b0, '0});
		append_row(rows, '{ACT_PUSH, 24'd3, 1'b0, '0});
		append_row(rows, '{ACT_PUSH, 24'd4, 1'b0, '0});
		append_row(rows, '{ACT_PUSH, 24'd4, 1'b0, '0});
		append_row(rows, '{ACT_PUSH, 24'd9, 1'b0, '0});
		append_row(rows, '{ACT_PUSH, 24'd9, 1'b0, '0});
		append_row(rows, '{ACT_FLUSH, '0, 1'b0, '0});
		// Run that ends at the top of the number space, next to zero.
		append_row(rows, '{ACT_PUSH, 24'hFF_FFFE, 1'b0, '0});
		append_row(rows, '{ACT_PUSH, '0, 1'b0, '0});
		append_row(rows, '{ACT_PUSH, 24'hFF_FFFF, 1'b0, '0});
		append_row(rows, '{ACT_FLUSH, '0, 1'b0, '0});
		foreach (rows[i]) begin
			row = rows[i];
			send_req(row.act, row.num, row.known, row.rec);
		end

		// Random part: bursts of pushes, each closed by a flush. The packet
		// id moves through its extremes and random values between bursts.
		ids[0] = 8'hFF;
		ids[1] = 8'h00;
		ids[2] = ID_BITS'($urandom_range(1, 254));
		ids[3] = ID_BITS'($urandom_range(0, 255));
		write_id(ids[0]);
		sent = 0;
		burst = 0;
		while (sent < RANDOM_REQ) begin
			if (burst == 1)
				hold_go = 1'b1;
			if (burst > 0 && burst % 4 == 0)
				write_id(ids[(burst / 4) % 4]);
			r = $urandom_range(99);
			if (burst == 2)
				len = CAPACITY;
			else if (r < 10)
				len = $urandom_range(CAPACITY, CAPACITY + 4);
			else
				len = $urandom_range(0, 12);
			style = (burst == 2) ? 2 : $urandom_range(0, 2);
			base = SEQ_W'($urandom_range(0, 24'hFF_FF00 - 2 * CAPACITY));
			for (int k = 0; k < len; k++) begin
				case (style)
					0: send_req(ACT_PUSH, SEQ_W'($urandom), 1'b0, '0);
					// Clustered numbers make runs and repeats.
					1: send_req(ACT_PUSH, SEQ_W'(base + $urandom_range(0, 15)), 1'b0, '0);
					// Every other number: each one is a record of its own.
					default: send_req(ACT_PUSH, SEQ_W'(base + 2 * k), 1'b0, '0);
				endcase
			end
			send_req(ACT_FLUSH, SEQ_W'($urandom), 1'b0, '0);
			sent += len + 1;
			burst++;
		end
		req.valid <= 1'b0;

		while (pending_recs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		errors += pending_recs.size();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
